### design/clpc_pkg.sv
// package with payload types, widths and the microcode program of the lattice point counter
`timescale 1ns / 1ps

package clpc_pkg;

    // field widths
    localparam int RADIUS_WIDTH = 31;
    localparam int LIMIT_WIDTH  = 31;
    localparam int POINTS_WIDTH = 16;

    // datapath widths derived from the radius width
    localparam int ROOT_WIDTH   = (RADIUS_WIDTH + 1) / 2;
    localparam int RAD_WIDTH    = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH    = ROOT_WIDTH + 3;
    localparam int COORD_WIDTH  = ROOT_WIDTH + 1;
    localparam int SQ_WIDTH     = RADIUS_WIDTH + 1;
    localparam int SUM_WIDTH    = RADIUS_WIDTH + 2;
    localparam int PAIRS_WIDTH  = ROOT_WIDTH + 1;
    localparam int COUNT_WIDTH  = PAIRS_WIDTH + 2;
    localparam int ITER_WIDTH   = $clog2(ROOT_WIDTH);
    localparam int STEP_WIDTH   = 3;

    localparam logic [POINTS_WIDTH-1:0] POINTS_MAX = '1;

    // input beat
    typedef struct packed {
        logic [RADIUS_WIDTH-1:0] radius_squared;
        logic [LIMIT_WIDTH-1:0]  point_limit;
    } t_req;

    // result beat
    typedef struct packed {
        logic [POINTS_WIDTH-1:0] lattice_points;
        logic                    possible;
    } t_rsp;

    typedef logic [STEP_WIDTH-1:0] t_step;

    // datapath operation of one control word
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SQRT,
        OP_INIT,
        OP_PAIR,
        OP_DONE
    } t_dp_op;

    // branch condition of one control word
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_START,
        JC_SQRT_MORE,
        JC_PAIRS_LEFT
    } t_jump_cond;

    // one control word: operation, branch condition and branch target
    typedef struct packed {
        t_dp_op     op;
        t_jump_cond cond;
        t_step      target;
    } t_uword;

    // program step addresses
    localparam t_step STEP_IDLE = 3'd0;
    localparam t_step STEP_SQRT = 3'd1;
    localparam t_step STEP_INIT = 3'd2;
    localparam t_step STEP_PAIR = 3'd3;
    localparam t_step STEP_DONE = 3'd4;

    // microcode rom
    function automatic t_uword ucode_rom(t_step pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE: w = '{op: OP_IDLE, cond: JC_NO_START,   target: STEP_IDLE};
            STEP_SQRT: w = '{op: OP_SQRT, cond: JC_SQRT_MORE,  target: STEP_SQRT};
            STEP_INIT: w = '{op: OP_INIT, cond: JC_NEVER,      target: STEP_IDLE};
            STEP_PAIR: w = '{op: OP_PAIR, cond: JC_PAIRS_LEFT, target: STEP_PAIR};
            STEP_DONE: w = '{op: OP_DONE, cond: JC_ALWAYS,     target: STEP_IDLE};
            default:   w = '{op: OP_IDLE, cond: JC_ALWAYS,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### design/circle_lattice_point_counter_unit.sv
// top level of the circle lattice point counter: microcoded sequencer and datapath
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+------------------------------------------
//  request  | i_req (t_req)             | beat taken when start is high, busy low
//  result   | o_result (t_rsp)          | beat valid for one cycle while o_valid
//
// Each beat runs the square root steps, one setup step, one pair step per move of
// the x or y pointer, one closing pair step and one finish step; o_valid follows
// in the next cycle. The pair step loop moves one pointer per cycle.
// Reset returns the step counter to idle and drops o_valid.
// Results cannot be stalled; busy stays high from accept until the finish step.
`timescale 1ns / 1ps

module circle_lattice_point_counter_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  clpc_pkg::t_req i_req,
    output logic           busy,
    output logic           o_valid,
    output clpc_pkg::t_rsp o_result
);

    // sequencer
    clpc_pkg::t_step  r_pc;
    clpc_pkg::t_step  n_pc;
    clpc_pkg::t_uword uw;
    logic             jump;

    // datapath registers
    logic [clpc_pkg::RADIUS_WIDTH-1:0] r_rsq;
    logic [clpc_pkg::LIMIT_WIDTH-1:0]  r_limit;
    logic [clpc_pkg::RAD_WIDTH-1:0]    r_rad;
    logic [clpc_pkg::REM_WIDTH-1:0]    r_rem;
    logic [clpc_pkg::ROOT_WIDTH-1:0]   r_root;
    logic [clpc_pkg::ITER_WIDTH-1:0]   r_iter;
    logic [clpc_pkg::COORD_WIDTH-1:0]  r_x;
    logic [clpc_pkg::COORD_WIDTH-1:0]  r_y;
    logic [clpc_pkg::SQ_WIDTH-1:0]     r_xx;
    logic [clpc_pkg::SQ_WIDTH-1:0]     r_yy;
    logic [clpc_pkg::PAIRS_WIDTH-1:0]  r_pairs;
    logic                              r_valid;
    clpc_pkg::t_rsp                    r_rsp;

    // combinational datapath terms
    logic [clpc_pkg::REM_WIDTH-1:0]   rem_sh;
    logic [clpc_pkg::REM_WIDTH-1:0]   trial;
    logic                             trial_ok;
    logic [clpc_pkg::SUM_WIDTH-1:0]   sum_sq;
    logic [clpc_pkg::SUM_WIDTH-1:0]   rsq_ext;
    logic                             pairs_left;
    logic [clpc_pkg::COUNT_WIDTH-1:0] count;
    logic                             accept;

    // control word fetch and branch decision
    always_comb begin
        uw = clpc_pkg::ucode_rom(r_pc);
        unique case (uw.cond)
            clpc_pkg::JC_NEVER:      jump = 1'b0;
            clpc_pkg::JC_ALWAYS:     jump = 1'b1;
            clpc_pkg::JC_NO_START:   jump = !start;
            clpc_pkg::JC_SQRT_MORE:  jump = (r_iter != '0);
            clpc_pkg::JC_PAIRS_LEFT: jump = pairs_left;
            default:                 jump = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        if (jump) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + clpc_pkg::t_step'(1);
        end
    end

    // handshake outputs
    always_comb begin
        busy   = (uw.op != clpc_pkg::OP_IDLE);
        accept = start && (uw.op == clpc_pkg::OP_IDLE);
    end

    // square root digit step and pair test
    always_comb begin
        rem_sh     = {r_rem[clpc_pkg::REM_WIDTH-3:0],
                      r_rad[clpc_pkg::RAD_WIDTH-1 -: 2]};
        trial      = {1'b0, r_root, 2'b01};
        trial_ok   = (rem_sh >= trial);
        sum_sq     = clpc_pkg::SUM_WIDTH'(r_xx) + clpc_pkg::SUM_WIDTH'(r_yy);
        rsq_ext    = clpc_pkg::SUM_WIDTH'(r_rsq);
        pairs_left = (r_x <= r_y);
        count      = {r_pairs, 2'b00};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= clpc_pkg::STEP_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= (uw.op == clpc_pkg::OP_DONE);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            clpc_pkg::OP_IDLE: begin
                if (accept) begin
                    r_rsq   <= i_req.radius_squared;
                    r_limit <= i_req.point_limit;
                    r_rad   <= clpc_pkg::RAD_WIDTH'(i_req.radius_squared);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_iter  <= clpc_pkg::ITER_WIDTH'(clpc_pkg::ROOT_WIDTH - 1);
                end
            end
            clpc_pkg::OP_SQRT: begin
                r_rad  <= {r_rad[clpc_pkg::RAD_WIDTH-3:0], 2'b00};
                r_iter <= r_iter - clpc_pkg::ITER_WIDTH'(1);
                if (trial_ok) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[clpc_pkg::ROOT_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[clpc_pkg::ROOT_WIDTH-2:0], 1'b0};
                end
            end
            clpc_pkg::OP_INIT: begin
                // y starts at the floor root, y*y is radius minus remainder
                r_y  <= clpc_pkg::COORD_WIDTH'(r_root);
                r_yy <= clpc_pkg::SQ_WIDTH'(r_rsq)
                        - clpc_pkg::SQ_WIDTH'(r_rem);
                r_x  <= clpc_pkg::COORD_WIDTH'(1);
                r_xx <= clpc_pkg::SQ_WIDTH'(1);
                // perfect square: the point on the axis counts once
                r_pairs <= clpc_pkg::PAIRS_WIDTH'((r_rem == '0) && (r_rsq != '0));
            end
            clpc_pkg::OP_PAIR: begin
                if (pairs_left) begin
                    if (sum_sq > rsq_ext) begin
                        // too far out: step y down, (y-1)^2 = y^2 - 2y + 1
                        r_y  <= r_y - clpc_pkg::COORD_WIDTH'(1);
                        r_yy <= r_yy - clpc_pkg::SQ_WIDTH'({r_y, 1'b0})
                                + clpc_pkg::SQ_WIDTH'(1);
                    end else begin
                        // step x up, (x+1)^2 = x^2 + 2x + 1
                        r_x  <= r_x + clpc_pkg::COORD_WIDTH'(1);
                        r_xx <= r_xx + clpc_pkg::SQ_WIDTH'({r_x, 1'b1});
                        if (sum_sq == rsq_ext) begin
                            // mirrored pair counts twice, diagonal once
                            if (r_x == r_y) begin
                                r_pairs <= r_pairs + clpc_pkg::PAIRS_WIDTH'(1);
                            end else begin
                                r_pairs <= r_pairs + clpc_pkg::PAIRS_WIDTH'(2);
                            end
                        end
                    end
                end
            end
            clpc_pkg::OP_DONE: begin
                if (count > clpc_pkg::COUNT_WIDTH'(clpc_pkg::POINTS_MAX)) begin
                    r_rsp.lattice_points <= clpc_pkg::POINTS_MAX;
                end else begin
                    r_rsp.lattice_points <= clpc_pkg::POINTS_WIDTH'(count);
                end
                r_rsp.possible <= (clpc_pkg::LIMIT_WIDTH'(count) <= r_limit);
            end
            default: begin
            end
        endcase
    end

    // result beat
    assign o_valid  = r_valid;
    assign o_result = r_rsp;

endmodule
